// ===== hdl/ncrd_pkg.sv =====
// Shared widths, codes and defaults of the node coordinate distance block.
package ncrd_pkg;

	// Fixed field widths of the streams and the configuration register.
	localparam int NODE_W      = 10;
	localparam int CFG_W       = 11;
	localparam int DIST_W      = 21;
	localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_NODES  = 1024;
	localparam int DEF_COORD_BITS = 24;

	// Node count after reset.
	localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(1024);

	// Item kinds carried in the input tuser bit.
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

endpackage

// ===== hdl/ncrd_store.sv =====
// Coordinate memories for x and y, one write port and one registered read port.
module ncrd_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 24
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_x,
	input  logic [DW-1:0] wr_y,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_x,
	output logic [DW-1:0] rd_y
);

	logic [DW-1:0] x_mem [DEPTH];
	logic [DW-1:0] y_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_mem[wr_addr] <= wr_x;
			y_mem[wr_addr] <= wr_y;
		end
	end

	always_ff @(posedge clk) begin
		rd_x <= x_mem[rd_addr];
		rd_y <= y_mem[rd_addr];
	end

endmodule

// ===== hdl/ncrd_isqrt.sv =====
// Digit-by-digit integer square root, one result bit per clock cycle.
module ncrd_isqrt #(
	parameter int K = 25
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [2*K-1:0] radicand,
	output logic           done,
	output logic [K-1:0]   root
);

	logic [2*K-1:0] rem_q;
	logic [2*K-1:0] root_q;
	logic [2*K-1:0] bit_q;
	logic           busy_q;
	logic           done_q;
	logic [2*K-1:0] trial;
	logic           take;

	assign trial = root_q + bit_q;
	assign take  = (rem_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && bit_q[0];
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The trial bit walks down two places per step, starting at the top even position.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= radicand;
			root_q <= '0;
			bit_q  <= (2*K)'(1) << (2*K-2);
		end else if (busy_q) begin
			if (take) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[K-1:0];

endmodule

// ===== hdl/node_coordinate_rounded_distance.sv =====
// Top level: coordinate store with rounded Euclidean distance queries.
// Write item: the result goes through the S_DONE state into the output register; the input is
// not ready for a new item until that result has entered the output register.
// Query item: the result goes through S_RDA, S_RDB, S_DIFF, S_SQX, S_SQY, S_ADD, S_ROOT (the
// bit-serial square root) and S_DONE; a new item is taken only back in S_IDLE.
// arst_n clears the sequencer, the output valid and the node count (to 1024); the
// coordinate memories are not cleared and hold nothing meaningful until written.
module node_coordinate_rounded_distance
	import ncrd_pkg::*;
#(
	parameter int MAX_NODES  = DEF_MAX_NODES,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	// Configuration write channel, carrying node_count.
	input  logic                                           cfg_valid,
	output logic                                           cfg_ready,
	input  logic [CFG_W-1:0]                               cfg_data,
	// Input stream.
	input  logic                                           s_axis_tvalid,
	output logic                                           s_axis_tready,
	// tdata from bit 0: node_a, node_b, x_coord, y_coord, zero padding.
	input  logic [((2*COORD_BITS+2*NODE_W+7)/8)*8-1:0]     s_axis_tdata,
	// tuser: mode.
	input  logic                                           s_axis_tuser,
	// Result stream.
	output logic                                           m_axis_tvalid,
	input  logic                                           m_axis_tready,
	// tdata from bit 0: distance, zero padding.
	output logic [OUT_TDATA_W-1:0]                         m_axis_tdata,
	// tuser: bad_node.
	output logic                                           m_axis_tuser
);

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int C  = COORD_BITS;
	// Number of result bits of the square root of a sum below 2^(2C+1).
	localparam int K  = C + 1;
	// Width for the rounding step, wide enough for (root >> 3) + 1 and for the output field.
	localparam int RW = (K - 2 > DIST_W) ? K - 2 : DIST_W;

	// One-hot sequencer states.
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_RDA  = 9'b000000010,
		S_RDB  = 9'b000000100,
		S_DIFF = 9'b000001000,
		S_SQX  = 9'b000010000,
		S_SQY  = 9'b000100000,
		S_ADD  = 9'b001000000,
		S_ROOT = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t state_q;

	// Unpacked input fields.
	logic [NODE_W-1:0] in_a;
	logic [NODE_W-1:0] in_b;
	logic [C-1:0]      in_x;
	logic [C-1:0]      in_y;

	assign in_a = s_axis_tdata[NODE_W-1:0];
	assign in_b = s_axis_tdata[2*NODE_W-1:NODE_W];
	assign in_x = s_axis_tdata[2*NODE_W+C-1:2*NODE_W];
	assign in_y = s_axis_tdata[2*NODE_W+2*C-1:2*NODE_W+C];

	logic [CFG_W-1:0] node_count_q;

	// A node number is usable when it is below both the configured count and the memory depth.
	function automatic logic node_ok(logic [NODE_W-1:0] n, logic [CFG_W-1:0] cnt);
		return (CFG_W'(n) < cnt) && (int'(n) < MAX_NODES);
	endfunction

	logic s_accept;
	logic a_ok;
	logic b_ok;

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign a_ok          = node_ok(in_a, node_count_q);
	assign b_ok          = node_ok(in_b, node_count_q);

	// The config register is always ready; the user must write it only while idle (not enforced).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	// Coordinate store. A write goes in at the edge of its input transfer.
	logic [AW-1:0] a_q;
	logic [AW-1:0] b_q;
	logic [AW-1:0] rd_addr;
	logic [C-1:0]  rd_x;
	logic [C-1:0]  rd_y;
	logic          wr_en;

	assign wr_en   = s_accept && (s_axis_tuser == MODE_WRITE) && a_ok;
	assign rd_addr = (state_q == S_RDB) ? b_q : a_q;

	ncrd_store #(
		.DEPTH (MAX_NODES),
		.AW    (AW),
		.DW    (C)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(in_a)),
		.wr_x    (in_x),
		.wr_y    (in_y),
		.rd_addr (rd_addr),
		.rd_x    (rd_x),
		.rd_y    (rd_y)
	);

	// Square root unit, started once the sum of squares is formed.
	logic           sqrt_start;
	logic           sqrt_done;
	logic [K-1:0]   sqrt_root;
	logic [C-1:0]   xa_q;
	logic [C-1:0]   ya_q;
	logic [C-1:0]   dxm_q;
	logic [C-1:0]   dym_q;
	logic [2*C-1:0] sq_q;
	logic [2*C-1:0] xsq_q;
	logic [2*K-1:0] radicand;

	assign sqrt_start = (state_q == S_ADD);
	assign radicand   = (2*K)'(xsq_q) + (2*K)'(sq_q);

	ncrd_isqrt #(
		.K (K)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (radicand),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// Coordinate differences as magnitudes; a difference of two C-bit values fits C+1 bits
	// signed and its magnitude fits C bits.
	logic signed [C:0] dx;
	logic signed [C:0] dy;
	logic        [C:0] dx_abs;
	logic        [C:0] dy_abs;

	assign dx     = $signed({xa_q[C-1], xa_q}) - $signed({rd_x[C-1], rd_x});
	assign dy     = $signed({ya_q[C-1], ya_q}) - $signed({rd_y[C-1], rd_y});
	assign dx_abs = dx[C] ? $unsigned(-dx) : $unsigned(dx);
	assign dy_abs = dy[C] ? $unsigned(-dy) : $unsigned(dy);

	// One multiplier serves both squares, x in one cycle and y in the next.
	logic [C-1:0]   mul_op;
	logic [2*C-1:0] mul_res;

	assign mul_op  = (state_q == S_SQX) ? dxm_q : dym_q;
	assign mul_res = (2*C)'(mul_op) * (2*C)'(mul_op);

	// Rounding half away from zero: d = ((floor(sqrt(S)) >> 3) + 1) >> 1.
	logic [RW-1:0] rnd;

	assign rnd = (RW'(sqrt_root >> 3) + RW'(1)) >> 1;

	logic              m_valid_q;
	logic              out_load;
	logic [DIST_W-1:0] res_dist_q;
	logic              res_bad_q;
	logic [DIST_W-1:0] dist_q;
	logic              bad_q;

	// The result moves into the output register as soon as that register is free or
	// is being emptied in the same cycle.
	assign out_load = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						if (s_axis_tuser == MODE_QUERY && a_ok && b_ok) begin
							state_q <= S_RDA;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_RDA:  state_q <= S_RDB;
				S_RDB:  state_q <= S_DIFF;
				S_DIFF: state_q <= S_SQX;
				S_SQX:  state_q <= S_SQY;
				S_SQY:  state_q <= S_ADD;
				S_ADD:  state_q <= S_ROOT;
				S_ROOT: begin
					if (sqrt_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			a_q        <= AW'(in_a);
			b_q        <= AW'(in_b);
			res_dist_q <= '0;
			// A write checks node_a only; a query checks both nodes.
			if (s_axis_tuser == MODE_WRITE) begin
				res_bad_q <= !a_ok;
			end else begin
				res_bad_q <= !(a_ok && b_ok);
			end
		end
		if (state_q == S_RDB) begin
			xa_q <= rd_x;
			ya_q <= rd_y;
		end
		if (state_q == S_DIFF) begin
			dxm_q <= dx_abs[C-1:0];
			dym_q <= dy_abs[C-1:0];
		end
		if (state_q == S_SQX || state_q == S_SQY) begin
			sq_q <= mul_res;
		end
		if (state_q == S_SQY) begin
			xsq_q <= sq_q;
		end
		if (state_q == S_ROOT && sqrt_done) begin
			res_dist_q <= rnd[DIST_W-1:0];
		end
	end

	// Output register, which parts the sequencer from the result stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dist_q <= res_dist_q;
			bad_q  <= res_bad_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(dist_q);
	assign m_axis_tuser  = bad_q;

endmodule

// ===== hdl/ncrd_checker.sv =====
// Port-level checks for the node coordinate distance block, bound to its top level.
module ncrd_checker
	import ncrd_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser
);

	// A result waiting on the output keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// A flagged node never comes with a distance.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[DIST_W-1:0] == '0)
		else $error("bad node result carries a distance");

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again right after a transfer");

	// A new result appears only while the block is busy finishing an item.
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared while the block was idle");

endmodule

bind node_coordinate_rounded_distance ncrd_checker u_ncrd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
